/* rtl/core/cable_wire_map_classifier_core_assert.svh */
// Assertion macros for the cable wire map classifier checker
`ifndef CABLE_WIRE_MAP_CLASSIFIER_CORE_ASSERT_SVH
`define CABLE_WIRE_MAP_CLASSIFIER_CORE_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent
`define CWMC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cwmc: next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent
`define CWMC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cwmc: same-cycle check failed");

`endif

/* rtl/core/cwmc_pkg.sv */
// Types, constants and helper functions of the cable wire map classifier
package cwmc_pkg;

  localparam int LANES   = 8;
  localparam int CNT_W   = 8;
  localparam int CODE_W  = 4;
  localparam int PIN_W   = 3;
  localparam int TYPE_W  = 2;
  localparam int OUT_W   = 40;
  localparam int DIVISOR = 31;
  localparam int HALF    = DIVISOR / 2;

  // Input beat kinds (in_tuser)
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_EVAL   = 1'b1;

  // Cable type codes
  localparam logic [TYPE_W-1:0] TYPE_UNKNOWN   = 2'd0;
  localparam logic [TYPE_W-1:0] TYPE_STRAIGHT  = 2'd1;
  localparam logic [TYPE_W-1:0] TYPE_CROSS     = 2'd2;
  localparam logic [TYPE_W-1:0] TYPE_CROSS100  = 2'd3;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [PIN_W-1:0]  pin_t;
  typedef code_t [LANES-1:0] map_t;
  typedef pin_t  [LANES-1:0] perm_t;

  // Unconnected wire
  localparam code_t NO_SOURCE = 4'd8;

  // Fixed permutations, element 0 in the low bits
  localparam perm_t FIRST_MAP  = {3'd0, 3'd7, 3'd6, 3'd1, 3'd2, 3'd3, 3'd5, 3'd4};
  localparam perm_t SECOND_MAP = {3'd1, 3'd2, 3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd0};

  // Reference wire maps, position 0 in the low bits
  localparam map_t PAT_STRAIGHT = {4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0};
  localparam map_t PAT_CROSS    = {4'd4, 4'd3, 4'd1, 4'd7, 4'd6, 4'd0, 4'd5, 4'd2};
  localparam map_t PAT_CROSS100 = {4'd7, 4'd6, 4'd1, 4'd4, 4'd3, 4'd0, 4'd5, 4'd2};

  // Lane control for one accepted beat
  typedef struct packed {
    logic sample;
    logic evaluate;
  } lane_ctl_t;

  // (cnt - 15) / 31 truncated toward zero, done as a threshold count
  function automatic pin_t src_index(input cnt_t cnt);
    pin_t idx;
    idx = '0;
    for (int k = 1; k < LANES; k++) begin
      if (cnt >= CNT_W'(HALF + DIVISOR * k)) begin
        idx = PIN_W'(k);
      end
    end
    return idx;
  endfunction

endpackage

/* rtl/core/cwmc_lane.sv */
// One wire lane: toggle counter and source pin decode
module cwmc_lane
  import cwmc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  lane_ctl_t ctl,
  input  logic      toggle,
  output code_t     src_code
);

  cnt_t count_r;
  cnt_t count_nxt;
  pin_t idx;

  // Count toggles, clear after an evaluate beat
  always_comb begin
    count_nxt = count_r;
    if (ctl.evaluate) begin
      count_nxt = '0;
    end else if (ctl.sample && toggle) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Decode the count into a remapped source pin
  assign idx = src_index(count_r);
  assign src_code = (count_r == '0) ? NO_SOURCE
                                    : {1'b0, SECOND_MAP[FIRST_MAP[idx]]};

endmodule

/* rtl/core/cwmc_merge.sv */
// Merge stage: place lane codes by wire position, classify, hold the result
module cwmc_merge
  import cwmc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  map_t              lane_codes,
  input  logic              out_ready,
  output logic              out_valid,
  output map_t              out_map,
  output logic [TYPE_W-1:0] out_type
);

  map_t              map;
  logic [TYPE_W-1:0] cable_type;
  logic              valid_r;
  logic              valid_nxt;
  map_t              map_r;
  logic [TYPE_W-1:0] type_r;

  // Scatter each lane to its wire position
  always_comb begin
    map = '0;
    for (int w = 0; w < LANES; w++) begin
      map[SECOND_MAP[w]] = lane_codes[w];
    end
  end

  // Match against the known cable patterns
  always_comb begin
    priority if (map == PAT_STRAIGHT) begin
      cable_type = TYPE_STRAIGHT;
    end else if (map == PAT_CROSS) begin
      cable_type = TYPE_CROSS;
    end else if (map == PAT_CROSS100) begin
      cable_type = TYPE_CROSS100;
    end else begin
      cable_type = TYPE_UNKNOWN;
    end
  end

  // Hold the result until the downstream takes it
  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      map_r  <= map;
      type_r <= cable_type;
    end
  end

  assign out_valid = valid_r;
  assign out_map   = map_r;
  assign out_type  = type_r;

endmodule

/* rtl/core/cable_wire_map_classifier_core.sv */
// Cable wire map classifier: counts wire toggles and reports the wire map on evaluate
// A sample beat updates the toggle counts; an evaluate beat puts its result on out_ in
// the cycle after acceptance. One beat per cycle is taken while the output register is
// free or being drained; in_tready drops only while a result waits on out_tready.
// Reset clears the stored levels, all eight toggle counts and the output valid flag.
module cable_wire_map_classifier_core
  import cwmc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] pin_levels
  input  logic             in_tuser,   // [0] kind
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // [3:0] wire0_source .. [31:28] wire7_source,
                                       // [33:32] cable_type, [39:34] zero
);

  logic              in_fire;
  logic [LANES-1:0]  last_levels_r;
  logic [LANES-1:0]  last_levels_nxt;
  logic [LANES-1:0]  diff;
  lane_ctl_t         ctl;
  map_t              lane_codes;
  map_t              out_map;
  logic [TYPE_W-1:0] out_type;

  // Accept whenever the output slot is free or draining
  assign in_tready = !out_tvalid || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign ctl = '{sample:   in_fire && (in_tuser == KIND_SAMPLE),
                 evaluate: in_fire && (in_tuser == KIND_EVAL)};

  // Track the last sampled levels
  assign diff            = last_levels_r ^ in_tdata;
  assign last_levels_nxt = ctl.sample ? in_tdata : last_levels_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_levels_r <= '0;
    end else begin
      last_levels_r <= last_levels_nxt;
    end
  end

  // One lane per wire
  for (genvar w = 0; w < LANES; w++) begin : g_lane
    cwmc_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .toggle   (diff[w]),
      .src_code (lane_codes[w])
    );
  end

  cwmc_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (ctl.evaluate),
    .lane_codes (lane_codes),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_map    (out_map),
    .out_type   (out_type)
  );

  assign out_tdata = {(OUT_W - LANES * CODE_W - TYPE_W)'(0), out_type, out_map};

endmodule

/* rtl/core/cwmc_checker.sv */
// Port-level checker for the cable wire map classifier, bound to the top level
`include "cable_wire_map_classifier_core_assert.svh"

module cwmc_checker
  import cwmc_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [7:0]       in_tdata,
  input logic             in_tuser,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // A stalled result beat holds
  `CWMC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // An accepted evaluate beat yields a result in the next cycle
  `CWMC_ASSERT_NEXT(a_eval_result, in_tvalid && in_tready && (in_tuser == KIND_EVAL), out_tvalid)

  // A sample beat taken while no result waits never produces a result
  `CWMC_ASSERT_NEXT(a_sample_silent,
    in_tvalid && in_tready && (in_tuser == KIND_SAMPLE) && !out_tvalid && (in_tdata == in_tdata),
    !out_tvalid)

  // A straight verdict carries the straight wire map
  `CWMC_ASSERT_SAME(a_straight_map, out_tvalid && (out_tdata[33:32] == TYPE_STRAIGHT),
    out_tdata[31:0] == PAT_STRAIGHT)

endmodule

bind cable_wire_map_classifier_core cwmc_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* sim/tb_cable_wire_map_classifier_core.sv */
// Self-checking testbench for the cable wire map classifier: wire toggle windows in, wire maps out
module tb_cable_wire_map_classifier_core;
  import cwmc_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int RESET_CYCLES  = 7;
  localparam int RANDOM_BEATS  = 1750;
  localparam int MIN_REPORTS   = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 20;
  localparam int LIMIT_TIME    = 2_000_000;
  localparam int MAX_SHOWN     = 10;

  // Count-to-pin conversion: (count - offset) / span, truncated toward zero
  localparam int TOGGLE_OFFSET = 15;
  localparam int TOGGLE_SPAN   = 31;

  // Fixed permutations and reference maps, element 0 in the low bits
  localparam logic [7:0][2:0] PIN_PERM  = {3'd0, 3'd7, 3'd6, 3'd1, 3'd2, 3'd3, 3'd5, 3'd4};
  localparam logic [7:0][2:0] POS_PERM  = {3'd1, 3'd2, 3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd0};
  localparam map_t STRAIGHT_WIRING = {4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0};
  localparam map_t CROSS_WIRING    = {4'd4, 4'd3, 4'd1, 4'd7, 4'd6, 4'd0, 4'd5, 4'd2};
  localparam map_t CROSS100_WIRING = {4'd7, 4'd6, 4'd1, 4'd4, 4'd3, 4'd0, 4'd5, 4'd2};

  typedef struct packed {
    logic       kind;
    logic [7:0] levels;
  } beat_t;

  typedef struct {
    map_t              wires;
    logic [TYPE_W-1:0] ctype;
  } wire_report_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata   = '0;
  logic             in_tuser   = KIND_SAMPLE;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  beat_t        pending_beats[$];
  wire_report_t expected_reports[$];

  // Predicted block state
  logic [7:0] seen_levels;
  cnt_t       wire_toggles [8];

  // Stimulus generator state
  logic [7:0] gen_levels = '0;
  int         gen_beats  = 0;
  int         gen_evals  = 0;
  int         win_counts [8];

  int total_beats = 0;
  int beats_taken = 0;
  int idle_phase  = 0;
  int mismatches  = 0;
  int hold_at     = 0;
  int hold_left   = 0;
  bit hold_done   = 1'b0;

  cable_wire_map_classifier_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #(HALF_PERIOD) clk = ~clk;

  task automatic push_sample(input logic [7:0] lv);
    beat_t b;
    b.kind = KIND_SAMPLE;
    b.levels = lv;
    pending_beats.push_back(b);
    gen_levels = lv;
    gen_beats++;
  endtask

  task automatic push_eval(input logic [7:0] lv);
    beat_t b;
    b.kind = KIND_EVAL;
    b.levels = lv;
    pending_beats.push_back(b);
    gen_beats++;
    gen_evals++;
  endtask

  // Toggle each wire win_counts[w] times in random order, then evaluate
  task automatic add_window();
    int         left [8];
    int         steps;
    logic [7:0] flip;
    steps = 0;
    for (int w = 0; w < 8; w++) begin
      left[w] = win_counts[w];
      if (left[w] > steps) steps = left[w];
    end
    while (steps > 0) begin
      if ($urandom_range(7) == 0) begin
        push_sample(gen_levels);
      end else begin
        flip = '0;
        for (int w = 0; w < 8; w++) begin
          if (left[w] == steps || (left[w] > 0 && $urandom_range(1) == 1)) begin
            flip[w] = 1'b1;
            left[w]--;
          end
        end
        push_sample(gen_levels ^ flip);
        steps--;
      end
    end
    push_eval(8'($urandom_range(255)));
  endtask

  task automatic flag_mismatch(input string what, input int want, input int got);
    if (mismatches < MAX_SHOWN) begin
      $display("mismatch %s: expected %0d, got %0d", what, want, got);
    end
    mismatches++;
  endtask

  // Build the stimulus, then wait for the last result
  initial begin : stimulus
    map_t       target;
    int         mode;
    int         pin;
    int         lo;
    int         hi;
    int         n;
    logic [3:0] v;

    // Evaluate with nothing counted, twice
    push_eval(8'h00);
    push_eval(8'hFF);
    // No change, all wires toggle twice
    push_sample(8'h00);
    push_sample(8'hFF);
    push_sample(8'hFF);
    push_sample(8'h00);
    push_eval(8'h5A);
    // Uneven counts across wires
    push_sample(8'h01);
    push_sample(8'h00);
    push_sample(8'h01);
    push_sample(8'hA5);
    push_sample(8'h80);
    push_eval(8'hA5);
    hold_at = gen_beats + 60;

    while (gen_beats < hold_at - 60 + RANDOM_BEATS || gen_evals < MIN_REPORTS) begin
      mode = $urandom_range(99);
      if (mode < 12) begin
        // Counts chosen to land on a target wire map
        case ($urandom_range(4))
          0: target = STRAIGHT_WIRING;
          1: target = CROSS_WIRING;
          2: target = CROSS100_WIRING;
          3: for (int p = 0; p < 8; p++) target[p] = 4'($urandom_range(8));
          default: begin
            target = STRAIGHT_WIRING;
            for (int s = 0; s < 6; s++) begin
              lo = $urandom_range(7);
              hi = $urandom_range(7);
              v = target[lo];
              target[lo] = target[hi];
              target[hi] = v;
            end
          end
        endcase
        if ($urandom_range(3) == 0) target[$urandom_range(7)] = 4'($urandom_range(8));
        for (int w = 0; w < 8; w++) begin
          v = target[POS_PERM[w]];
          if (v == NO_SOURCE) begin
            win_counts[w] = 0;
          end else begin
            pin = 0;
            for (int k = 0; k < 8; k++) begin
              if (POS_PERM[PIN_PERM[k]] == v[2:0]) pin = k;
            end
            lo = (pin == 0) ? 1 : TOGGLE_OFFSET + TOGGLE_SPAN * pin;
            hi = (pin == 7) ? 255 : TOGGLE_OFFSET + TOGGLE_SPAN * pin + TOGGLE_SPAN - 1;
            win_counts[w] = $urandom_range(hi, lo);
          end
        end
        add_window();
      end else if (mode < 72) begin
        // Small counts around the low thresholds
        for (int w = 0; w < 8; w++) begin
          win_counts[w] = ($urandom_range(3) == 0) ? 0 : $urandom_range(50);
        end
        add_window();
      end else if (mode < 77) begin
        // Counts near and past the wrap
        for (int w = 0; w < 8; w++) begin
          win_counts[w] = $urandom_range(1) ? $urandom_range(270, 240) : $urandom_range(20);
        end
        add_window();
      end else begin
        // Random beats, closed by an evaluate
        n = $urandom_range(10, 1);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(3) == 0) push_eval(8'($urandom_range(255)));
          else push_sample(8'($urandom_range(255)));
        end
        push_eval(8'($urandom_range(255)));
      end
    end
    total_beats = gen_beats;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (!(rst_n && beats_taken == total_beats && expected_reports.size() == 0)) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("cable_wire_map_classifier_core regression: pass");
    end else begin
      $display("cable_wire_map_classifier_core regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_TIME);
    $display("cable_wire_map_classifier_core regression: fail");
    $finish;
  end

  // Drive input beats and predict the result of each accepted one
  always @(posedge clk) begin : drive_in
    beat_t             nxt;
    logic [7:0]        diff;
    map_t              wmap;
    logic [TYPE_W-1:0] ctype;
    int                cnt;
    int                pin;
    int                pct;
    wire_report_t      rep;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= KIND_SAMPLE;
      seen_levels = '0;
      for (int w = 0; w < 8; w++) wire_toggles[w] = '0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (in_tuser == KIND_SAMPLE) begin
          diff = seen_levels ^ in_tdata;
          for (int w = 0; w < 8; w++) begin
            if (diff[w]) wire_toggles[w] = wire_toggles[w] + 1'b1;
          end
          seen_levels = in_tdata;
        end else begin
          for (int w = 0; w < 8; w++) begin
            cnt = int'(wire_toggles[w]);
            if (cnt == 0) begin
              wmap[POS_PERM[w]] = NO_SOURCE;
            end else begin
              pin = (cnt <= TOGGLE_OFFSET) ? 0 : (cnt - TOGGLE_OFFSET) / TOGGLE_SPAN;
              wmap[POS_PERM[w]] = {1'b0, POS_PERM[PIN_PERM[pin]]};
            end
          end
          if (wmap == STRAIGHT_WIRING) ctype = TYPE_STRAIGHT;
          else if (wmap == CROSS_WIRING) ctype = TYPE_CROSS;
          else if (wmap == CROSS100_WIRING) ctype = TYPE_CROSS100;
          else ctype = TYPE_UNKNOWN;
          rep.wires = wmap;
          rep.ctype = ctype;
          expected_reports.push_back(rep);
          for (int w = 0; w < 8; w++) wire_toggles[w] = '0;
        end
        beats_taken <= beats_taken + 1;
      end
      pct = (idle_phase == 1) ? 51 : (idle_phase == 3) ? 11 : 0;
      if (!in_tvalid || in_tready) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= pct) begin
          nxt = pending_beats.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= nxt.levels;
          in_tuser  <= nxt.kind;
          idle_phase <= ((total_beats - pending_beats.size()) * 4) / total_beats;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off once, early in the run, so the input stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && beats_taken >= hold_at) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Receiver backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= (hold_left == 0) &&
                    ($urandom_range(99) >= ((idle_phase == 2) ? 51 : (idle_phase == 3) ? 11 : 0));
    end
  end

  // Check each result beat against the oldest prediction
  always @(posedge clk) begin : check_out
    wire_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_reports.size() == 0) begin
        flag_mismatch("unexpected result beat", -1, int'(out_tdata));
      end else begin
        want = expected_reports.pop_front();
        for (int w = 0; w < 8; w++) begin
          if (out_tdata[4*w +: 4] !== want.wires[w]) begin
            flag_mismatch($sformatf("wire%0d_source", w), int'(want.wires[w]),
                          int'(out_tdata[4*w +: 4]));
          end
        end
        if (out_tdata[33:32] !== want.ctype) begin
          flag_mismatch("cable_type", int'(want.ctype), int'(out_tdata[33:32]));
        end
      end
    end
  end

endmodule
